// ===== sv/mjt_pkg.sv =====
`default_nettype none

package mjt_pkg;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_RECLAIM = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_CANCELED = 3'd3;
  localparam logic [2:0] ST_NOSPACE  = 3'd4;
  localparam logic [2:0] ST_PENDING  = 3'd5;

  localparam logic [1:0] PH_RUNNING  = 2'd1;
  localparam logic [1:0] PH_CANCELED = 2'd2;
  localparam logic [1:0] PH_FINISHED = 2'd3;

  // At most this many expiries are reported for one tick.
  localparam int MAX_FIRED = 16;
  localparam int CNT_W     = $clog2(MAX_FIRED + 1);

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] period;
    logic        periodic;
    logic [7:0]  slot_id;
    logic        id_ok;
  } cmd_t;

  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
  } q_head_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic        periodic;
    logic [15:0] reload;
    logic [15:0] ticks;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/mjt_req_if.sv =====
`default_nettype none

interface mjt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] period;
  logic        periodic;
  logic [7:0]  slot_id;

  modport source (output valid, output op, output period, output periodic, output slot_id,
                  input ready);
  modport sink (input valid, input op, input period, input periodic, input slot_id,
                output ready);
endinterface

`default_nettype wire

// ===== sv/mjt_rsp_if.sv =====
`default_nettype none

interface mjt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] slot_out;
  logic       fired;
  logic       last;

  modport source (output valid, output status, output slot_out, output fired, output last,
                  input ready);
  modport sink (input valid, input status, input slot_out, input fired, input last,
                output ready);
endinterface

`default_nettype wire

// ===== sv/mjt_front.sv =====
`default_nettype none

module mjt_front #(
  parameter int JOB_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  mjt_req_if.sink         req,
  output mjt_pkg::q_head_t head,
  input  logic            pop
);
  import mjt_pkg::*;

  cmd_t       in_cmd;
  cmd_t       q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_en;
  logic       pop_en;

  // Classify the request: the range check on slot_id is settled here so the
  // back end only has to look at the table.
  always_comb begin
    in_cmd.op       = req.op;
    in_cmd.period   = req.period;
    in_cmd.periodic = req.periodic;
    in_cmd.slot_id  = req.slot_id;
    in_cmd.id_ok    = (req.slot_id < 8'(JOB_SLOTS));
  end

  assign req.ready = (count != 2'd2);
  assign push_en   = req.valid && req.ready;
  assign pop_en    = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.cmd   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) begin
      q_mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push_en} - {1'b0, pop_en});
    end
  end

endmodule

`default_nettype wire

// ===== sv/mjt_back.sv =====
`default_nettype none

module mjt_back #(
  parameter int JOB_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  mjt_pkg::q_head_t head,
  output logic             pop,
  mjt_rsp_if.source        rsp
);
  import mjt_pkg::*;

  localparam int IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_ONE   = 3'd2;
  localparam logic [2:0] S_TICK  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]           state, state_next;
  logic [IW-1:0]        idx, idx_next;
  logic [IW-1:0]        held, held_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  cmd_t                 cmd, cmd_next;
  logic [JOB_SLOTS-1:0] slot_used;
  entry_t               slot_mem [JOB_SLOTS];
  entry_t               rdata;
  entry_t               wdata;
  logic                 we;
  logic                 set_used;
  logic                 clr_used;

  logic                 o_valid;
  logic [2:0]           o_status;
  logic [3:0]           o_slot;
  logic                 o_fired;
  logic                 o_last;

  logic                 push;
  logic [2:0]           p_status;
  logic [3:0]           p_slot;
  logic                 p_fired;
  logic                 p_last;

  logic                 can_push;
  logic                 last_idx;
  logic                 active;
  logic                 expire;
  logic                 record;
  logic                 need_push;

  assign can_push  = !o_valid || rsp.ready;
  assign last_idx  = (idx == IW'(JOB_SLOTS - 1));
  assign active    = slot_used[idx] && (rdata.phase == PH_RUNNING) && (rdata.ticks != 16'd0);
  assign expire    = active && (rdata.ticks == 16'd1);
  assign record    = expire && (cnt < CNT_W'(MAX_FIRED));
  // A new expiry lets the previous one go out, since it is now known not to be last.
  assign need_push = record && (cnt != '0);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    held_next  = held;
    cnt_next   = cnt;
    cmd_next   = cmd;
    pop        = 1'b0;
    we         = 1'b0;
    wdata      = rdata;
    set_used   = 1'b0;
    clr_used   = 1'b0;
    push       = 1'b0;
    p_status   = ST_OK;
    p_slot     = 4'd0;
    p_fired    = 1'b0;
    p_last     = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          cmd_next = head.cmd;
          idx_next = '0;
          cnt_next = '0;
          unique case (head.cmd.op)
            OP_ADD:  state_next = S_ADD;
            OP_TICK: state_next = S_TICK;
            OP_CANCEL, OP_RECLAIM: begin
              state_next = S_ONE;
              if (head.cmd.id_ok) begin
                idx_next = head.cmd.slot_id[IW-1:0];
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_ADD: begin
        if (!slot_used[idx]) begin
          if (can_push) begin
            push           = 1'b1;
            p_slot         = 4'(idx);
            we             = 1'b1;
            wdata.phase    = PH_RUNNING;
            wdata.periodic = cmd.periodic;
            wdata.reload   = cmd.period;
            wdata.ticks    = cmd.period;
            set_used       = 1'b1;
            state_next     = S_IDLE;
          end
        end else if (last_idx) begin
          if (can_push) begin
            push       = 1'b1;
            p_status   = ST_NOSPACE;
            state_next = S_IDLE;
          end
        end else begin
          idx_next = IW'(idx + 1'b1);
        end
      end

      S_ONE: begin
        if (can_push) begin
          push       = 1'b1;
          state_next = S_IDLE;
          if (!cmd.id_ok || !slot_used[idx]) begin
            p_status = ST_INVALID;
          end else if (cmd.op == OP_CANCEL) begin
            priority if (rdata.phase == PH_CANCELED) begin
              p_status = ST_CANCELED;
            end else if (rdata.phase == PH_FINISHED) begin
              p_status = ST_BUSY;
            end else begin
              we          = 1'b1;
              wdata.phase = PH_CANCELED;
            end
          end else begin
            priority if (rdata.periodic) begin
              p_status = ST_BUSY;
            end else if (rdata.phase == PH_CANCELED || rdata.phase == PH_FINISHED) begin
              clr_used = 1'b1;
            end else begin
              p_status = ST_PENDING;
            end
          end
        end
      end

      S_TICK: begin
        if (!need_push || can_push) begin
          if (active) begin
            we          = 1'b1;
            wdata.ticks = 16'(rdata.ticks - 16'd1);
            if (expire) begin
              if (rdata.periodic) begin
                wdata.ticks = rdata.reload;
              end else begin
                wdata.phase = PH_FINISHED;
              end
            end
          end
          if (record) begin
            held_next = idx;
            cnt_next  = CNT_W'(cnt + 1'b1);
          end
          if (need_push) begin
            push    = 1'b1;
            p_slot  = 4'(held);
            p_fired = 1'b1;
            p_last  = 1'b0;
          end
          if (last_idx) begin
            state_next = S_FLUSH;
          end else begin
            idx_next = IW'(idx + 1'b1);
          end
        end
      end

      S_FLUSH: begin
        if (can_push) begin
          push       = 1'b1;
          state_next = S_IDLE;
          if (cnt != '0) begin
            p_slot  = 4'(held);
            p_fired = 1'b1;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // The read address runs one step ahead so the entry is ready when the step needs it.
  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[idx] <= wdata;
    end
    rdata <= slot_mem[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot_used <= '0;
      o_valid   <= 1'b0;
      idx       <= '0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
      if (set_used) begin
        slot_used[idx] <= 1'b1;
      end
      if (clr_used) begin
        slot_used[idx] <= 1'b0;
      end
      if (push) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
    cmd  <= cmd_next;
    if (push) begin
      o_status <= p_status;
      o_slot   <= p_slot;
      o_fired  <= p_fired;
      o_last   <= p_last;
    end
  end

  assign rsp.valid    = o_valid;
  assign rsp.status   = o_status;
  assign rsp.slot_out = o_slot;
  assign rsp.fired    = o_fired;
  assign rsp.last     = o_last;

endmodule

`default_nettype wire

// ===== sv/multi_slot_job_timer.sv =====
// Timer table with JOB_SLOTS slots. Requests arrive on req (op, period, periodic,
// slot_id) and results leave on rsp (status, slot_out, fired, last), both with
// valid/ready handshakes. Every request yields at least one result; the final
// result of a request carries last.
// A two-entry queue sits between the request side and the sequencer, so requests
// are taken while the sequencer works or while a result waits at the output.
// The sequencer handles one request at a time and owns the slot table, one entry
// read and one written per cycle:
//   cancel, reclaim: one read of the named slot, then its result.
//   add: a search in slot order for the first free slot, which it claims.
//   tick: a walk over every slot that counts down each running entry.
// A request waits in the queue until the sequencer is idle and takes it, and its
// first result is valid the cycle after the sequencer produces it.
// When rsp.ready stays low, the output register holds its result and the
// sequencer waits at the next result; the queue then fills and req.ready drops.
// Reset frees every slot and empties the queue and the output register.
`default_nettype none

module multi_slot_job_timer #(
  parameter int JOB_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  mjt_req_if.sink   req,
  mjt_rsp_if.source rsp
);
  import mjt_pkg::*;

  q_head_t head;
  logic    pop;

  mjt_front #(
    .JOB_SLOTS (JOB_SLOTS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .head (head),
    .pop  (pop)
  );

  mjt_back #(
    .JOB_SLOTS (JOB_SLOTS)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("sequencer took a request from an empty queue");

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.fired) |-> (rsp.status == ST_OK))
    else $error("expiry result with a status other than ok");

  a_nospace_single: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_NOSPACE) |-> (rsp.last && rsp.slot_out == 4'd0))
    else $error("no-space result is not a single result with slot zero");

endmodule

`default_nettype wire
